/* rtl/bnrt_pkg.sv */
// ----------------------------------------------------------------------------
// bnrt_pkg
// Shared types, register indexes and helpers for the batch NACK receive
// tracker.
// ----------------------------------------------------------------------------
package bnrt_pkg;

    localparam int SIZE_W     = 7;
    localparam int TOTAL_W    = 11;
    localparam int BATCH_W    = 11;
    localparam int SEQ_W      = 16;
    localparam int SLOT_W     = 6;
    localparam int MAP_W      = 64;
    localparam int REPORT_W   = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam int DEF_MAX_BATCH   = 64;
    localparam int DEF_MAX_BATCHES = 1024;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BATCH_PACKETS      = 2'd0,
        REG_LAST_BATCH_PACKETS = 2'd1,
        REG_BATCH_TOTAL        = 2'd2
    } cfg_reg_t;

    typedef enum logic {
        CMD_PACKET = 1'b0,
        CMD_TICK   = 1'b1
    } cmd_t;

    typedef struct packed {
        logic             command;
        logic [SEQ_W-1:0] seq_number;
    } in_item_t;

    typedef struct packed {
        logic                accepted;
        logic [SLOT_W-1:0]   slot;
        logic [SEQ_W-1:0]    packet_index;
        logic [REPORT_W-1:0] report_batch;
        logic [MAP_W-1:0]    received_bits;
        logic                batch_complete;
        logic                transfer_done;
    } out_item_t;

    typedef struct packed {
        cmd_t             op;
        logic [SEQ_W-1:0] seq;
    } op_entry_t;

    typedef struct packed {
        logic      valid;
        op_entry_t entry;
    } op_queue_t;

    function automatic logic [SIZE_W-1:0] clamp_size(
        input logic [SIZE_W-1:0] v,
        input logic [SIZE_W-1:0] max_v
    );
        logic [SIZE_W-1:0] r;
        if (v == '0) begin
            r = SIZE_W'(1);
        end else if (v > max_v) begin
            r = max_v;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

/* rtl/bnrt_front.sv */
// ----------------------------------------------------------------------------
// bnrt_front
// Accepts request items, decodes the command and holds them in a two-entry
// queue for the execution stage.
// ----------------------------------------------------------------------------
module bnrt_front import bnrt_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output op_queue_t q_head,
    input  logic      q_pop
);

    op_entry_t   entries_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push;
    logic        pop;
    op_entry_t   new_entry;

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && (count_reg != 2'd0);

    always_comb begin
        new_entry.op  = s_data.command ? CMD_TICK : CMD_PACKET;
        new_entry.seq = s_data.seq_number;
    end

    assign q_head.valid = (count_reg != 2'd0);
    assign q_head.entry = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entries_reg[wr_ptr_reg] <= new_entry;
        end
    end

endmodule

/* rtl/bnrt_back.sv */
// ----------------------------------------------------------------------------
// bnrt_back
// Executes queued operations against the batch number and received map and
// registers one result per operation.
// ----------------------------------------------------------------------------
module bnrt_back import bnrt_pkg::*; #(
    parameter int MAX_BATCH   = DEF_MAX_BATCH,
    parameter int MAX_BATCHES = DEF_MAX_BATCHES
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [SIZE_W-1:0]   batch_packets,
    input  logic [SIZE_W-1:0]   last_batch_packets,
    input  logic [TOTAL_W-1:0]  batch_total,
    input  op_queue_t           q_head,
    output logic                q_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output out_item_t           m_data
);

    localparam logic [SIZE_W-1:0] MaxSize  = SIZE_W'(MAX_BATCH);
    localparam logic [16:0]       MaxTotal = 17'(MAX_BATCHES);

    logic [BATCH_W-1:0] batch_reg, batch_next;
    logic [MAP_W-1:0]   map_reg, map_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_reg, out_next;

    logic [SIZE_W-1:0]  bp;
    logic [SIZE_W-1:0]  size;
    logic [16:0]        total_wide;
    logic [TOTAL_W-1:0] total;
    logic               done;
    logic [SEQ_W-1:0]   base;
    logic [SEQ_W:0]     diff;
    logic               in_window;
    logic [SLOT_W-1:0]  slot;
    logic               is_new;
    logic [17:0]        product;
    logic [MAP_W-1:0]   size_mask;
    logic               full;

    assign q_pop   = q_head.valid && (!out_valid_reg || m_ready);
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    always_comb begin
        bp         = clamp_size(batch_packets, MaxSize);
        total_wide = (batch_total == '0) ? 17'd1 : 17'(batch_total);
        if (total_wide > MaxTotal) begin
            total_wide = MaxTotal;
        end
        total = total_wide[TOTAL_W-1:0];
        done  = (batch_reg >= total);
        size  = (12'(batch_reg) + 12'd1 == 12'(total))
              ? clamp_size(last_batch_packets, MaxSize) : bp;
        base      = batch_reg[0] ? SEQ_W'(bp) : '0;
        diff      = {1'b0, q_head.entry.seq} - {1'b0, base};
        in_window = !diff[SEQ_W] && (diff < (SEQ_W+1)'(size));
        slot      = diff[SLOT_W-1:0];
        is_new    = !map_reg[slot];
        product   = 18'(batch_reg) * 18'(bp);
        for (int i = 0; i < MAP_W; i++) begin
            size_mask[i] = (SIZE_W'(i) < size);
        end
        full = ((map_reg & size_mask) == size_mask);
    end

    always_comb begin
        batch_next     = batch_reg;
        map_next       = map_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (q_pop) begin
            out_valid_next = 1'b1;
            out_next       = '0;
            unique case (q_head.entry.op)
                CMD_PACKET: begin
                    if (!done && in_window && is_new) begin
                        map_next              = map_reg | (MAP_W'(1) << slot);
                        out_next.accepted     = 1'b1;
                        out_next.slot         = slot;
                        out_next.packet_index = product[SEQ_W-1:0] + SEQ_W'(slot);
                    end
                end
                CMD_TICK: begin
                    out_next.report_batch  = batch_reg[REPORT_W-1:0];
                    out_next.received_bits = map_reg;
                    if (!done && full) begin
                        out_next.batch_complete = 1'b1;
                        batch_next              = batch_reg + BATCH_W'(1);
                        map_next                = '0;
                    end
                end
                default: ;
            endcase
            out_next.transfer_done = (batch_next >= total);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            batch_reg     <= '0;
            map_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            batch_reg     <= batch_next;
            map_reg       <= map_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

endmodule

/* rtl/batch_nack_receive_tracker_top.sv */
// ----------------------------------------------------------------------------
// batch_nack_receive_tracker_top
// Receiver-side tracker for a batched selective-repeat transfer.
// ----------------------------------------------------------------------------
// The s_ channel carries one request per item: a packet arrival with its
// sequence number, or an acknowledgement tick. The m_ channel returns exactly
// one result per request, in order: for a packet, whether it was new and in
// the window with its slot and packet index; for a tick, the batch number,
// the received map and whether the batch completed and advanced.
// The cfg_ channel writes the three size registers; it is always ready and
// should only be used while no request is in flight.
// A request passes a two-entry queue and one execution stage: it is written
// into the queue on acceptance, then the execution stage takes it from the
// queue head and registers its result. The execution stage handles one
// request per cycle while m_ready is high, so the block then sustains one
// request per clock. When the m_ side stalls, the result register holds, the
// queue fills and s_ready drops once both queue entries are occupied.
// Reset clears the batch number, the received map, the queue and the result
// valid flag, and restores the register defaults (64, 64 and 1).
// ----------------------------------------------------------------------------
module batch_nack_receive_tracker_top import bnrt_pkg::*; #(
    parameter int MAX_BATCH   = DEF_MAX_BATCH,
    parameter int MAX_BATCHES = DEF_MAX_BATCHES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [SIZE_W-1:0]  batch_packets_reg;
    logic [SIZE_W-1:0]  last_batch_packets_reg;
    logic [TOTAL_W-1:0] batch_total_reg;
    op_queue_t          q_head;
    logic               q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            batch_packets_reg      <= SIZE_W'(64);
            last_batch_packets_reg <= SIZE_W'(64);
            batch_total_reg        <= TOTAL_W'(1);
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_BATCH_PACKETS:      batch_packets_reg      <= cfg_data[SIZE_W-1:0];
                REG_LAST_BATCH_PACKETS: last_batch_packets_reg <= cfg_data[SIZE_W-1:0];
                REG_BATCH_TOTAL:        batch_total_reg        <= cfg_data[TOTAL_W-1:0];
                default: ;
            endcase
        end
    end

    bnrt_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_head  (q_head),
        .q_pop   (q_pop)
    );

    bnrt_back #(
        .MAX_BATCH   (MAX_BATCH),
        .MAX_BATCHES (MAX_BATCHES)
    ) u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .batch_packets      (batch_packets_reg),
        .last_batch_packets (last_batch_packets_reg),
        .batch_total        (batch_total_reg),
        .q_head             (q_head),
        .q_pop              (q_pop),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_data             (m_data)
    );

endmodule

/* rtl/bnrt_checker.sv */
// ----------------------------------------------------------------------------
// bnrt_checker
// Port-level checks on the result channel of the receive tracker.
// ----------------------------------------------------------------------------
module bnrt_checker import bnrt_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    a_packet_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.accepted |->
            m_data.received_bits == '0 && !m_data.batch_complete
            && m_data.report_batch == '0)
        else $error("accepted packet carries tick fields");

    a_reject_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.accepted |-> m_data.slot == '0 && m_data.packet_index == '0)
        else $error("rejected packet carries slot or index");

    a_complete_map: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.batch_complete |-> m_data.received_bits[0])
        else $error("batch completed without its first slot");

endmodule

bind batch_nack_receive_tracker_top bnrt_checker u_bnrt_checker (.*);

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the batch NACK receive tracker.
// A behavioral tracker predicts one result for every accepted request and
// every result from the block is compared with it field by field. Directed
// requests cover the window edges, register limits and the end of transfer.
// A stall test fills the block while the output is held off. Random
// transfers then run with random register settings and random idling.
// ----------------------------------------------------------------------------
module tb;
    import bnrt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SLOTS      = DEF_MAX_BATCH;
    localparam int MAX_TOTAL      = DEF_MAX_BATCHES;
    localparam int MAX_GAP        = 18;
    localparam int HOLD_CYCLES    = 80;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_ITEMS   = 1400;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_item_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_item_t             m_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic [SIZE_W-1:0]  reg_batch_packets = SIZE_W'(DEF_MAX_BATCH);
    logic [SIZE_W-1:0]  reg_last_packets  = SIZE_W'(DEF_MAX_BATCH);
    logic [TOTAL_W-1:0] reg_batch_total   = TOTAL_W'(1);
    int unsigned        tracked_batch     = 0;
    logic [MAP_W-1:0]   tracked_map       = '0;

    out_item_t   expected_results[$];
    int unsigned requests_sent = 0;
    int          error_count   = 0;
    int          quiet_cycles  = 0;
    bit          no_gaps       = 1'b0;
    bit          hold_pending  = 1'b0;

    batch_nack_receive_tracker_top #(
        .MAX_BATCH   (MAX_SLOTS),
        .MAX_BATCHES (MAX_TOTAL)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int unsigned eff_size(input logic [SIZE_W-1:0] v);
        if (v == '0) begin
            return 1;
        end else if (v > MAX_SLOTS) begin
            return MAX_SLOTS;
        end
        return v;
    endfunction

    function automatic int unsigned eff_total();
        if (reg_batch_total == '0) begin
            return 1;
        end else if (reg_batch_total > MAX_TOTAL) begin
            return MAX_TOTAL;
        end
        return reg_batch_total;
    endfunction

    function automatic bit transfer_finished();
        return tracked_batch >= eff_total();
    endfunction

    function automatic int unsigned window_base();
        return tracked_batch[0] ? eff_size(reg_batch_packets) : 0;
    endfunction

    function automatic int unsigned window_size();
        if (tracked_batch + 1 == eff_total()) begin
            return eff_size(reg_last_packets);
        end
        return eff_size(reg_batch_packets);
    endfunction

    function automatic out_item_t track_request(input in_item_t req);
        out_item_t        res;
        int unsigned      base;
        int unsigned      span;
        int unsigned      slot_pos;
        logic [MAP_W-1:0] full_mask;
        res  = '0;
        base = window_base();
        span = window_size();
        if (req.command == CMD_PACKET) begin
            if (!transfer_finished() && req.seq_number >= base
                    && req.seq_number - base < span) begin
                slot_pos = req.seq_number - base;
                if (!tracked_map[slot_pos]) begin
                    tracked_map[slot_pos] = 1'b1;
                    res.accepted     = 1'b1;
                    res.slot         = SLOT_W'(slot_pos);
                    res.packet_index = SEQ_W'(tracked_batch * eff_size(reg_batch_packets)
                                              + slot_pos);
                end
            end
        end else begin
            res.report_batch  = REPORT_W'(tracked_batch);
            res.received_bits = tracked_map;
            if (!transfer_finished()) begin
                full_mask = (span >= MAP_W) ? {MAP_W{1'b1}} : ((MAP_W'(1) << span) - MAP_W'(1));
                if ((tracked_map & full_mask) == full_mask) begin
                    res.batch_complete = 1'b1;
                    tracked_batch++;
                    tracked_map = '0;
                end
            end
        end
        res.transfer_done = transfer_finished();
        return res;
    endfunction

    function automatic void compare_field(input string field, input logic [MAP_W-1:0] want,
                                          input logic [MAP_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
            error_count++;
        end
    endfunction

    function automatic logic [CFG_DATA_W-1:0] draw_size();
        case ($urandom_range(0, 19))
            0: begin
                return '0;
            end
            1: begin
                return CFG_DATA_W'($urandom_range(MAX_SLOTS + 1, {SIZE_W{1'b1}}));
            end
            2: begin
                return CFG_DATA_W'($urandom);
            end
            3, 4, 5: begin
                return CFG_DATA_W'($urandom_range(9, MAX_SLOTS));
            end
            default: begin
                return CFG_DATA_W'($urandom_range(1, 8));
            end
        endcase
    endfunction

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_BATCH_PACKETS: begin
                reg_batch_packets = value[SIZE_W-1:0];
            end
            REG_LAST_BATCH_PACKETS: begin
                reg_last_packets = value[SIZE_W-1:0];
            end
            REG_BATCH_TOTAL: begin
                reg_batch_total = value[TOTAL_W-1:0];
            end
            default: begin
            end
        endcase
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_request(input cmd_t cmd, input logic [SEQ_W-1:0] seq);
        int unsigned gap;
        in_item_t    req;
        req.command    = cmd;
        req.seq_number = seq;
        gap = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_results.push_back(track_request(req));
        requests_sent++;
    endtask

    task automatic send_stray(input int unsigned base, input int unsigned span);
        case ($urandom_range(0, 3))
            0: begin
                send_request(CMD_PACKET, SEQ_W'($urandom));
            end
            1: begin
                send_request(CMD_PACKET, SEQ_W'(base + span));
            end
            2: begin
                send_request(CMD_PACKET, SEQ_W'(base - 1));
            end
            default: begin
                send_request(CMD_TICK, SEQ_W'($urandom));
            end
        endcase
    endtask

    task automatic send_batch(input bit with_noise);
        int unsigned      base;
        int unsigned      span;
        int unsigned      held_back;
        int unsigned      pick;
        logic [SEQ_W-1:0] order[MAX_SLOTS];
        logic [SEQ_W-1:0] swap;
        base = window_base();
        span = window_size();
        for (int i = 0; i < span; i++) begin
            order[i] = SEQ_W'(base + i);
        end
        for (int i = span - 1; i > 0; i--) begin
            pick        = $urandom_range(0, i);
            swap        = order[i];
            order[i]    = order[pick];
            order[pick] = swap;
        end
        held_back = (with_noise && span > 1 && $urandom_range(0, 9) == 0) ? 1 : 0;
        for (int i = 0; i < span - held_back; i++) begin
            if (with_noise && $urandom_range(0, 9) == 0) begin
                send_stray(base, span);
            end
            send_request(CMD_PACKET, order[i]);
        end
        if (held_back != 0) begin
            send_request(CMD_TICK, SEQ_W'($urandom));
            send_request(CMD_PACKET, order[span - 1]);
        end
        send_request(CMD_TICK, SEQ_W'($urandom));
    endtask

    task automatic test_default_window();
        send_request(CMD_PACKET, '0);
        send_request(CMD_PACKET, SEQ_W'(MAX_SLOTS - 1));
        send_request(CMD_PACKET, SEQ_W'(MAX_SLOTS));
        send_request(CMD_PACKET, '1);
        send_request(CMD_PACKET, '0);
        send_request(CMD_TICK, '0);
    endtask

    task automatic test_size_saturation();
        write_register(REG_LAST_BATCH_PACKETS, '0);
        write_register(REG_BATCH_PACKETS, CFG_DATA_W'({SIZE_W{1'b1}}));
        write_register(CFG_UNUSED_INDEX, '1);
        send_request(CMD_TICK, '1);
        send_request(CMD_PACKET, '0);
        send_request(CMD_TICK, '0);
    endtask

    task automatic test_total_limits();
        write_register(REG_BATCH_TOTAL, '0);
        send_request(CMD_TICK, '0);
        write_register(REG_BATCH_TOTAL, '1);
        send_request(CMD_PACKET, SEQ_W'(MAX_SLOTS - 1));
        send_request(CMD_PACKET, SEQ_W'(MAX_SLOTS));
        send_request(CMD_PACKET, SEQ_W'(2 * MAX_SLOTS - 1));
        send_request(CMD_PACKET, SEQ_W'(2 * MAX_SLOTS));
        write_register(REG_BATCH_PACKETS, CFG_DATA_W'(1));
        send_request(CMD_PACKET, SEQ_W'(1));
        send_request(CMD_TICK, '0);
        send_request(CMD_PACKET, '0);
        send_request(CMD_TICK, '0);
    endtask

    task automatic test_output_stall();
        write_register(REG_BATCH_PACKETS, CFG_DATA_W'(16));
        write_register(REG_BATCH_TOTAL, CFG_DATA_W'(MAX_TOTAL));
        hold_pending = 1'b1;
        no_gaps      = 1'b1;
        send_batch(1'b0);
        send_batch(1'b0);
        no_gaps = 1'b0;
    endtask

    task automatic test_random_transfers();
        int unsigned stop_at;
        int unsigned batches;
        logic [CFG_DATA_W-1:0] total;
        stop_at = requests_sent + RANDOM_ITEMS;
        while (requests_sent < stop_at) begin
            case ($urandom_range(0, 9))
                0: begin
                    total = '0;
                end
                1: begin
                    total = CFG_DATA_W'($urandom_range(MAX_TOTAL, {CFG_DATA_W{1'b1}}));
                end
                2: begin
                    total = CFG_DATA_W'(tracked_batch);
                end
                default: begin
                    total = CFG_DATA_W'(tracked_batch + $urandom_range(1, 4));
                end
            endcase
            write_register(REG_BATCH_PACKETS, draw_size());
            write_register(REG_LAST_BATCH_PACKETS, draw_size());
            write_register(REG_BATCH_TOTAL, total);
            no_gaps = ($urandom_range(0, 3) == 0);
            batches = $urandom_range(1, 6);
            for (int b = 0; b < batches && !transfer_finished(); b++) begin
                send_batch(1'b1);
            end
            repeat ($urandom_range(1, 3)) send_stray(window_base(), window_size());
            send_request(CMD_TICK, SEQ_W'($urandom));
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_BATCH_PACKETS;
        cfg_data  <= '0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_default_window();
        test_size_saturation();
        test_total_limits();
        test_output_stall();
        test_random_transfers();
        wait_drained();
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin : result_monitor
        int unsigned stall;
        out_item_t   want;
        m_ready <= 1'b0;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if (hold_pending) begin
                hold_pending = 1'b0;
                stall = HOLD_CYCLES;
            end else begin
                stall = no_gaps ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            if (expected_results.size() == 0) begin
                $error("Result 0x%0h arrived with no request outstanding.", m_data);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                compare_field("accepted", want.accepted, m_data.accepted);
                compare_field("slot", want.slot, m_data.slot);
                compare_field("packet_index", want.packet_index, m_data.packet_index);
                compare_field("report_batch", want.report_batch, m_data.report_batch);
                compare_field("received_bits", want.received_bits, m_data.received_bits);
                compare_field("batch_complete", want.batch_complete, m_data.batch_complete);
                compare_field("transfer_done", want.transfer_done, m_data.transfer_done);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
